/* sv/bcim_pkg.sv */
// Shared types and constants for the block-cyclic index mapper.
// No dependencies; the files that use it refer to it by scoped names.
package bcim_pkg;

  typedef enum logic {
    OP_FWD = 1'b0,
    OP_INV = 1'b1
  } op_t;

  // front-to-back handshake group
  typedef struct packed {
    logic valid;
    op_t  op;
  } cls_t;

  localparam int BS_W     = 13;
  localparam int GRID_W   = 9;
  localparam int MYRANK_W = 16;
  localparam int POS_W    = 8;
  localparam int LROWS_W  = 21;
  localparam int OFF_W    = 40;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [2:0] REG_BLOCK_SIZE  = 3'd0;
  localparam logic [2:0] REG_GRID_ROWS   = 3'd1;
  localparam logic [2:0] REG_GRID_COLS   = 3'd2;
  localparam logic [2:0] REG_MY_RANK     = 3'd3;
  localparam logic [2:0] REG_MY_PROC_ROW = 3'd4;
  localparam logic [2:0] REG_MY_PROC_COL = 3'd5;
  localparam logic [2:0] REG_LOCAL_ROWS  = 3'd6;

  localparam logic [BS_W-1:0]    BLOCK_SIZE_RST = 13'd64;
  localparam logic [GRID_W-1:0]  GRID_RST       = 9'd1;
  localparam logic [LROWS_W-1:0] LROWS_RST      = 21'd1;

endpackage

/* sv/bcim_front.sv */
// Front end of the index mapper: input queue that accepts and classifies items.
// Depends on bcim_pkg.
module bcim_front #(
  parameter int INDEX_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic                  op,
  input  logic [INDEX_BITS-1:0] row_index,
  input  logic [INDEX_BITS-1:0] col_index,
  output bcim_pkg::cls_t        cls,
  output logic [INDEX_BITS-1:0] row_q,
  output logic [INDEX_BITS-1:0] col_q,
  input  logic                  take
);

  bcim_pkg::op_t         op_mem  [2];
  logic [INDEX_BITS-1:0] row_mem [2];
  logic [INDEX_BITS-1:0] col_mem [2];
  logic                  wp;
  logic                  rp;
  logic [1:0]            cnt;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (cnt == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = take && (cnt != 2'd0);

  assign cls.valid = (cnt != 2'd0);
  assign cls.op    = op_mem[rp];
  assign row_q     = row_mem[rp];
  assign col_q     = col_mem[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      op_mem[wp]  <= op ? bcim_pkg::OP_INV : bcim_pkg::OP_FWD;
      row_mem[wp] <= row_index;
      col_mem[wp] <= col_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

/* sv/bcim_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
// No package dependencies.
module bcim_div #(
  parameter int N  = 20,
  parameter int D  = 13,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [N-1:0]  dividend,
  input  logic [D-1:0]  divisor,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [N-1:0]  quot,
  output logic [D-1:0]  rem,
  output logic [SW-1:0] out_side
);

  logic          v_q    [N];
  logic [D-1:0]  rem_q  [N];
  logic [N-1:0]  dq_q   [N];
  logic [SW-1:0] side_q [N];

  logic          v_i    [N];
  logic [D-1:0]  rem_i  [N];
  logic [N-1:0]  dq_i   [N];
  logic [SW-1:0] side_i [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [D:0] trial;
    logic       ge;

    if (k == 0) begin : g_first
      assign v_i[k]    = in_valid;
      assign rem_i[k]  = '0;
      assign dq_i[k]   = dividend;
      assign side_i[k] = in_side;
    end else begin : g_next
      assign v_i[k]    = v_q[k-1];
      assign rem_i[k]  = rem_q[k-1];
      assign dq_i[k]   = dq_q[k-1];
      assign side_i[k] = side_q[k-1];
    end

    assign trial = {rem_i[k], dq_i[k][N-1]};
    assign ge    = (trial >= {1'b0, divisor});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? D'(trial - {1'b0, divisor}) : trial[D-1:0];
        dq_q[k]   <= {dq_i[k][N-2:0], ge};
        side_q[k] <= side_i[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_i[k];
      end
    end
  end

  assign out_valid = v_q[N-1];
  assign quot      = dq_q[N-1];
  assign rem       = rem_q[N-1];
  assign out_side  = side_q[N-1];

endmodule

/* sv/bcim_back.sv */
// Back end of the index mapper: two divider levels, map and offset multiply
// stages, and a two-entry result queue. Depends on bcim_pkg and bcim_div.
module bcim_back #(
  parameter int INDEX_BITS = 20,
  parameter int RANK_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bcim_pkg::cls_t                 cls,
  input  logic [INDEX_BITS-1:0]          row_q,
  input  logic [INDEX_BITS-1:0]          col_q,
  output logic                           take,
  input  logic [bcim_pkg::BS_W-1:0]      bsz,
  input  logic [bcim_pkg::GRID_W-1:0]    grows,
  input  logic [bcim_pkg::GRID_W-1:0]    gcols,
  input  logic [bcim_pkg::MYRANK_W-1:0]  myrank,
  input  logic [bcim_pkg::POS_W-1:0]     prow,
  input  logic [bcim_pkg::POS_W-1:0]     pcol,
  input  logic [bcim_pkg::LROWS_W-1:0]   lrows,
  output logic                           empty,
  input  logic                           pop,
  output logic [RANK_BITS-1:0]           owner_rank,
  output logic [INDEX_BITS-1:0]          out_row,
  output logic [INDEX_BITS-1:0]          out_col,
  output logic [bcim_pkg::OFF_W-1:0]     local_offset,
  output logic                           is_mine
);

  localparam int N   = INDEX_BITS;
  localparam int BW  = bcim_pkg::BS_W;
  localparam int GW  = bcim_pkg::GRID_W;
  localparam int PW  = bcim_pkg::LROWS_W + N + 1;
  localparam int SWD = (PW > bcim_pkg::OFF_W) ? PW : bcim_pkg::OFF_W;

  logic en;
  logic [1:0] ocnt;

  // Advance the whole pipe only while the result queue has room.
  assign en   = (ocnt != 2'd2);
  assign take = en;

  // Level one: index / block size
  logic          r1_v, c1_v;
  logic [N-1:0]  r1_q, c1_q;
  logic [BW-1:0] r1_m, c1_m;
  logic [N:0]    r1_sd;
  logic [N-1:0]  c1_sd;

  bcim_div #(.N(N), .D(BW), .SW(N + 1)) u_div_r1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(cls.valid), .dividend(row_q),
    .divisor(bsz), .in_side({cls.op == bcim_pkg::OP_INV, row_q}),
    .out_valid(r1_v), .quot(r1_q), .rem(r1_m), .out_side(r1_sd)
  );

  bcim_div #(.N(N), .D(BW), .SW(N)) u_div_c1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(cls.valid), .dividend(col_q),
    .divisor(bsz), .in_side(col_q),
    .out_valid(c1_v), .quot(c1_q), .rem(c1_m), .out_side(c1_sd)
  );

  // Level two: block index / grid size
  localparam int RS = 1 + N + BW + N;
  localparam int CS = N + BW + N;
  logic          r2_v, c2_v;
  logic [N-1:0]  r2_q, c2_q;
  logic [GW-1:0] r2_m, c2_m;
  logic [RS-1:0] r2_sd;
  logic [CS-1:0] c2_sd;

  bcim_div #(.N(N), .D(GW), .SW(RS)) u_div_r2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(r1_v && c1_v), .dividend(r1_q),
    .divisor(grows), .in_side({r1_sd, r1_m, r1_q}),
    .out_valid(r2_v), .quot(r2_q), .rem(r2_m), .out_side(r2_sd)
  );

  bcim_div #(.N(N), .D(GW), .SW(CS)) u_div_c2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(r1_v && c1_v), .dividend(c1_q),
    .divisor(gcols), .in_side({c1_sd, c1_m, c1_q}),
    .out_valid(c2_v), .quot(c2_q), .rem(c2_m), .out_side(c2_sd)
  );

  logic          d_inv;
  logic [N-1:0]  d_r, d_c, d_rblk, d_cblk;
  logic [BW-1:0] d_rm, d_cm;

  assign {d_inv, d_r, d_rm, d_rblk} = r2_sd;
  assign {d_c, d_cm, d_cblk}        = c2_sd;

  // Select stage: high part of the map (quotient or inverse block base) and rank
  logic [GW+N-1:0] inv_r_prod, inv_c_prod;
  logic [2*GW-1:0] rank_sum;

  assign inv_r_prod = (GW+N)'(grows) * (GW+N)'(d_rblk) + (GW+N)'(prow);
  assign inv_c_prod = (GW+N)'(gcols) * (GW+N)'(d_cblk) + (GW+N)'(pcol);
  assign rank_sum   = (2*GW)'(r2_m) * (2*GW)'(gcols) + (2*GW)'(c2_m);

  logic                 s_v, s_inv;
  logic [N-1:0]         s_r, s_c, s_hir, s_hic;
  logic [BW-1:0]        s_lor, s_loc;
  logic [RANK_BITS-1:0] s_rank;

  always_ff @(posedge clk) begin
    if (en) begin
      s_inv  <= d_inv;
      s_r    <= d_r;
      s_c    <= d_c;
      s_hir  <= d_inv ? inv_r_prod[N-1:0] : r2_q;
      s_hic  <= d_inv ? inv_c_prod[N-1:0] : c2_q;
      s_lor  <= d_rm;
      s_loc  <= d_cm;
      s_rank <= d_inv ? myrank[RANK_BITS-1:0] : rank_sum[RANK_BITS-1:0];
    end
  end

  // Map stage: high * block + low
  logic [N+BW-1:0] map_r, map_c;
  assign map_r = (N+BW)'(s_hir) * (N+BW)'(bsz) + (N+BW)'(s_lor);
  assign map_c = (N+BW)'(s_hic) * (N+BW)'(bsz) + (N+BW)'(s_loc);

  logic                 m_v, m_mine;
  logic [N-1:0]         m_orow, m_ocol, m_lrow, m_lcol;
  logic [RANK_BITS-1:0] m_rank;

  always_ff @(posedge clk) begin
    if (en) begin
      m_orow <= map_r[N-1:0];
      m_ocol <= map_c[N-1:0];
      m_lrow <= s_inv ? s_r : map_r[N-1:0];
      m_lcol <= s_inv ? s_c : map_c[N-1:0];
      m_rank <= s_rank;
      m_mine <= s_inv || (bcim_pkg::MYRANK_W'(s_rank) == myrank);
    end
  end

  // Offset stage: local row + leading dimension * local column
  logic [SWD-1:0] off_sum;
  assign off_sum = SWD'(m_lrow) + SWD'(lrows) * SWD'(m_lcol);

  logic                        f_v, f_mine;
  logic [N-1:0]                f_orow, f_ocol;
  logic [RANK_BITS-1:0]        f_rank;
  logic [bcim_pkg::OFF_W-1:0]  f_off;

  always_ff @(posedge clk) begin
    if (en) begin
      f_orow <= m_orow;
      f_ocol <= m_ocol;
      f_rank <= m_rank;
      f_mine <= m_mine;
      f_off  <= off_sum[bcim_pkg::OFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_v <= 1'b0;
      m_v <= 1'b0;
      f_v <= 1'b0;
    end else if (en) begin
      s_v <= r2_v && c2_v;
      m_v <= s_v;
      f_v <= m_v;
    end
  end

  // Result queue
  logic [RANK_BITS-1:0]       q_rank [2];
  logic [N-1:0]               q_row  [2];
  logic [N-1:0]               q_col  [2];
  logic [bcim_pkg::OFF_W-1:0] q_off  [2];
  logic                       q_mine [2];
  logic                       owp, orp;
  logic                       o_push, o_pop;

  assign o_push = en && f_v;
  assign o_pop  = pop && (ocnt != 2'd0);
  assign empty  = (ocnt == 2'd0);

  assign owner_rank   = q_rank[orp];
  assign out_row      = q_row[orp];
  assign out_col      = q_col[orp];
  assign local_offset = q_off[orp];
  assign is_mine      = q_mine[orp];

  always_ff @(posedge clk) begin
    if (o_push) begin
      q_rank[owp] <= f_rank;
      q_row[owp]  <= f_orow;
      q_col[owp]  <= f_ocol;
      q_off[owp]  <= f_off;
      q_mine[owp] <= f_mine;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= 1'b0;
      orp  <= 1'b0;
      ocnt <= 2'd0;
    end else begin
      if (o_push) owp <= ~owp;
      if (o_pop) orp <= ~orp;
      ocnt <= ocnt + {1'b0, o_push} - {1'b0, o_pop};
    end
  end

endmodule

/* sv/block_cyclic_index_map.sv */
// Top level of the block-cyclic index mapper: configuration registers and
// the front queue feeding the back pipeline. Depends on bcim_pkg,
// bcim_front, bcim_back.
//
// Two-dimensional block-cyclic index mapper. Push an item (op, row_index,
// col_index) while full is low; pop results while empty is low. op 0 maps a
// global position to its owner rank, local row/column, column-major local
// offset and an ownership flag; op 1 maps a local position of this process
// (at grid position my_proc_row, my_proc_col) back to global row/column.
// The block takes one item per clock and returns one result per clock while
// the result queue has room. Each item passes through two levels of
// pipelined restoring dividers (by block size, then by grid size) of
// INDEX_BITS stages each, one select stage, one map multiply stage, one
// offset multiply stage and the result queue. A stalled consumer freezes the
// back pipeline; the two-entry queues on each side keep the input open while
// a finished result waits. A zero block size or grid size acts as one.
// Write registers only while the block is idle; the APB port has no wait
// states. Registers sit at byte addresses 4*i in this order: block_size,
// grid_rows, grid_cols, my_rank, my_proc_row, my_proc_col, local_rows.
module block_cyclic_index_map #(
  parameter int INDEX_BITS = 20,
  parameter int RANK_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bcim_pkg::ADDR_W-1:0]       paddr,
  input  logic [bcim_pkg::DATA_W-1:0]       pwdata,
  output logic [bcim_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  input  logic                              push,
  output logic                              full,
  input  logic                              op,
  input  logic [INDEX_BITS-1:0]             row_index,
  input  logic [INDEX_BITS-1:0]             col_index,
  output logic                              empty,
  input  logic                              pop,
  output logic [RANK_BITS-1:0]              owner_rank,
  output logic [INDEX_BITS-1:0]             out_row,
  output logic [INDEX_BITS-1:0]             out_col,
  output logic [bcim_pkg::OFF_W-1:0]        local_offset,
  output logic                              is_mine
);

  logic [bcim_pkg::BS_W-1:0]     block_size;
  logic [bcim_pkg::GRID_W-1:0]   grid_rows;
  logic [bcim_pkg::GRID_W-1:0]   grid_cols;
  logic [bcim_pkg::MYRANK_W-1:0] my_rank;
  logic [bcim_pkg::POS_W-1:0]    my_proc_row;
  logic [bcim_pkg::POS_W-1:0]    my_proc_col;
  logic [bcim_pkg::LROWS_W-1:0]  local_rows;

  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes; the upper data bits beyond each field are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size  <= bcim_pkg::BLOCK_SIZE_RST;
      grid_rows   <= bcim_pkg::GRID_RST;
      grid_cols   <= bcim_pkg::GRID_RST;
      my_rank     <= '0;
      my_proc_row <= '0;
      my_proc_col <= '0;
      local_rows  <= bcim_pkg::LROWS_RST;
    end else if (wr_en) begin
      case (reg_idx)
        bcim_pkg::REG_BLOCK_SIZE:  block_size  <= pwdata[bcim_pkg::BS_W-1:0];
        bcim_pkg::REG_GRID_ROWS:   grid_rows   <= pwdata[bcim_pkg::GRID_W-1:0];
        bcim_pkg::REG_GRID_COLS:   grid_cols   <= pwdata[bcim_pkg::GRID_W-1:0];
        bcim_pkg::REG_MY_RANK:     my_rank     <= pwdata[bcim_pkg::MYRANK_W-1:0];
        bcim_pkg::REG_MY_PROC_ROW: my_proc_row <= pwdata[bcim_pkg::POS_W-1:0];
        bcim_pkg::REG_MY_PROC_COL: my_proc_col <= pwdata[bcim_pkg::POS_W-1:0];
        bcim_pkg::REG_LOCAL_ROWS:  local_rows  <= pwdata[bcim_pkg::LROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      bcim_pkg::REG_BLOCK_SIZE:  prdata = bcim_pkg::DATA_W'(block_size);
      bcim_pkg::REG_GRID_ROWS:   prdata = bcim_pkg::DATA_W'(grid_rows);
      bcim_pkg::REG_GRID_COLS:   prdata = bcim_pkg::DATA_W'(grid_cols);
      bcim_pkg::REG_MY_RANK:     prdata = bcim_pkg::DATA_W'(my_rank);
      bcim_pkg::REG_MY_PROC_ROW: prdata = bcim_pkg::DATA_W'(my_proc_row);
      bcim_pkg::REG_MY_PROC_COL: prdata = bcim_pkg::DATA_W'(my_proc_col);
      bcim_pkg::REG_LOCAL_ROWS:  prdata = bcim_pkg::DATA_W'(local_rows);
      default:                   prdata = '0;
    endcase
  end

  // Treat a zero divisor as one.
  logic [bcim_pkg::BS_W-1:0]   bsz;
  logic [bcim_pkg::GRID_W-1:0] grows;
  logic [bcim_pkg::GRID_W-1:0] gcols;

  assign bsz   = (block_size == '0) ? bcim_pkg::BS_W'(1) : block_size;
  assign grows = (grid_rows == '0) ? bcim_pkg::GRID_W'(1) : grid_rows;
  assign gcols = (grid_cols == '0) ? bcim_pkg::GRID_W'(1) : grid_cols;

  bcim_pkg::cls_t        cls;
  logic [INDEX_BITS-1:0] row_q;
  logic [INDEX_BITS-1:0] col_q;
  logic                  take;

  bcim_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .op(op),
    .row_index(row_index), .col_index(col_index),
    .cls(cls), .row_q(row_q), .col_q(col_q), .take(take)
  );

  bcim_back #(.INDEX_BITS(INDEX_BITS), .RANK_BITS(RANK_BITS)) u_back (
    .clk(clk), .rst(rst), .cls(cls), .row_q(row_q), .col_q(col_q),
    .take(take), .bsz(bsz), .grows(grows), .gcols(gcols), .myrank(my_rank),
    .prow(my_proc_row), .pcol(my_proc_col), .lrows(local_rows),
    .empty(empty), .pop(pop), .owner_rank(owner_rank), .out_row(out_row),
    .out_col(out_col), .local_offset(local_offset), .is_mine(is_mine)
  );

endmodule
